>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion helpers, clocked on clk and idle in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/ptt_ctrl_pkg.sv
// ----------------------------------------------------------------------------
// ptt_ctrl_pkg
// Types, codes and helper functions of the push-to-talk controller.
// ----------------------------------------------------------------------------
package ptt_ctrl_pkg;

	// default width of the stored timestamp
	localparam int PTT_TIME_WIDTH = 32;

	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ARM_THRESHOLD    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_RECORDING    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECORDING    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_TIMEOUT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PLAYBACK     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LINGER     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_VOICE_ENABLED    = 3'd6;

	// configuration reset values
	localparam logic [CFG_W-1:0] RST_ARM_THRESHOLD    = 20'd300;
	localparam logic [CFG_W-1:0] RST_MIN_RECORDING    = 20'd300;
	localparam logic [CFG_W-1:0] RST_MAX_RECORDING    = 20'd15000;
	localparam logic [CFG_W-1:0] RST_RESPONSE_TIMEOUT = 20'd20000;
	localparam logic [CFG_W-1:0] RST_MAX_PLAYBACK     = 20'd60000;
	localparam logic [CFG_W-1:0] RST_ERROR_LINGER     = 20'd2000;
	localparam logic             RST_VOICE_ENABLED    = 1'b1;

	// request codes
	localparam logic [3:0] REQ_PRESS       = 4'd0;
	localparam logic [3:0] REQ_RELEASE     = 4'd1;
	localparam logic [3:0] REQ_CANCEL      = 4'd2;
	localparam logic [3:0] REQ_RESP_READY  = 4'd3;
	localparam logic [3:0] REQ_RESP_ANSWER = 4'd4;
	localparam logic [3:0] REQ_RESP_FAILED = 4'd5;
	localparam logic [3:0] REQ_PLAY_DONE   = 4'd6;
	localparam logic [3:0] REQ_MUTE_TOGGLE = 4'd7;
	localparam logic [3:0] REQ_TIMEOUT     = 4'd8;
	localparam logic [3:0] REQ_TICK        = 4'd9;
	localparam logic [3:0] REQ_SET_MUTE    = 4'd10;

	// mode codes as seen on the result
	localparam logic [2:0] MODE_IDLE  = 3'd0;
	localparam logic [2:0] MODE_ARMED = 3'd1;
	localparam logic [2:0] MODE_REC   = 3'd2;
	localparam logic [2:0] MODE_WAIT  = 3'd3;
	localparam logic [2:0] MODE_PLAY  = 3'd4;
	localparam logic [2:0] MODE_MUTED = 3'd5;
	localparam logic [2:0] MODE_ERROR = 3'd6;

	// led codes
	localparam logic [2:0] LED_OFF   = 3'd0;
	localparam logic [2:0] LED_ARMED = 3'd1;
	localparam logic [2:0] LED_REC   = 3'd2;
	localparam logic [2:0] LED_WAIT  = 3'd3;
	localparam logic [2:0] LED_PLAY  = 3'd4;
	localparam logic [2:0] LED_ERROR = 3'd5;

	// earcon codes
	localparam logic [2:0] TONE_ACK    = 3'd0;
	localparam logic [2:0] TONE_LSTART = 3'd1;
	localparam logic [2:0] TONE_LSTOP  = 3'd2;
	localparam logic [2:0] TONE_READY  = 3'd3;
	localparam logic [2:0] TONE_ERROR  = 3'd4;
	localparam logic [2:0] TONE_MUTED  = 3'd5;

	// cause codes
	localparam logic [2:0] CAUSE_NONE    = 3'd0;
	localparam logic [2:0] CAUSE_MUTED   = 3'd1;
	localparam logic [2:0] CAUSE_VOICE   = 3'd2;
	localparam logic [2:0] CAUSE_LINK    = 3'd3;
	localparam logic [2:0] CAUSE_SHORT   = 3'd4;
	localparam logic [2:0] CAUSE_TIMEOUT = 3'd5;
	localparam logic [2:0] CAUSE_UPLOAD  = 3'd6;

	// action bits
	localparam logic [6:0] ACT_MIC_START  = 7'h01;
	localparam logic [6:0] ACT_MIC_STOP   = 7'h02;
	localparam logic [6:0] ACT_DISCARD    = 7'h04;
	localparam logic [6:0] ACT_UPLOAD     = 7'h08;
	localparam logic [6:0] ACT_CANCEL     = 7'h10;
	localparam logic [6:0] ACT_PLAY_START = 7'h20;
	localparam logic [6:0] ACT_PLAY_STOP  = 7'h40;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_ARMED = 7'b0000010,
		ST_REC   = 7'b0000100,
		ST_WAIT  = 7'b0001000,
		ST_PLAY  = 7'b0010000,
		ST_MUTED = 7'b0100000,
		ST_ERROR = 7'b1000000
	} ptt_state_t;

	typedef struct packed {
		logic [3:0]  req_type;
		logic [31:0] now_ms;
		logic        link_ready;
		logic        mute_value;
	} ptt_req_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       led_update;
		logic [2:0] led_code;
		logic       tone_valid;
		logic [2:0] tone_code;
		logic [2:0] cause;
		logic [6:0] actions;
		logic       muted_now;
		logic       press_used;
	} ptt_rsp_t;

	// external mode code of a state
	function automatic logic [2:0] mode_code(ptt_state_t st);
		logic [2:0] code;
		case (st)
			ST_IDLE:  code = MODE_IDLE;
			ST_ARMED: code = MODE_ARMED;
			ST_REC:   code = MODE_REC;
			ST_WAIT:  code = MODE_WAIT;
			ST_PLAY:  code = MODE_PLAY;
			ST_MUTED: code = MODE_MUTED;
			ST_ERROR: code = MODE_ERROR;
			default:  code = MODE_IDLE;
		endcase
		return code;
	endfunction

	// led pattern shown on entry to a state, muted shows off
	function automatic logic [2:0] led_of(ptt_state_t st);
		logic [2:0] code;
		case (st)
			ST_ARMED: code = LED_ARMED;
			ST_REC:   code = LED_REC;
			ST_WAIT:  code = LED_WAIT;
			ST_PLAY:  code = LED_PLAY;
			ST_ERROR: code = LED_ERROR;
			default:  code = LED_OFF;
		endcase
		return code;
	endfunction

endpackage

>>> hdl/push_to_talk_controller_core.sv
// ----------------------------------------------------------------------------
// push_to_talk_controller_core
// Seven-state push-to-talk controller: events, ticks and mute commands in,
// one status result per beat out.
// ----------------------------------------------------------------------------
// One request beat may be taken every clock cycle; its result is registered at
// the accepting edge and shows on the rsp channel in the cycle after acceptance,
// or later behind a result that is still waiting there. The whole decision
// (elapsed time subtract, timeout compare and state decode) is made in the
// accepting cycle and lands in a two-entry result queue, so req_stall rises
// only when two results are waiting to be taken. Configuration writes take
// effect on the next beat. Timestamps are kept in TIME_WIDTH bits.
`include "assert_macros.svh"

module push_to_talk_controller_core #(
	parameter int TIME_WIDTH = ptt_ctrl_pkg::PTT_TIME_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [ptt_ctrl_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ptt_ctrl_pkg::CFG_W-1:0]      cfg_wdata,
	// request channel
	input  logic                                req_valid,
	output logic                                req_stall,
	input  ptt_ctrl_pkg::ptt_req_t              req,
	// result channel
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output ptt_ctrl_pkg::ptt_rsp_t              rsp
);

	import ptt_ctrl_pkg::*;

	localparam int CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

	// configuration registers
	logic [CFG_W-1:0] arm_thr_q, min_rec_q, max_rec_q, resp_to_q, max_play_q, linger_q;
	logic             voice_en_q;

	// controller state
	ptt_state_t            state_q;
	logic [TIME_WIDTH-1:0] entered_q;
	logic                  mute_q, held_q, cons_q;
	logic [2:0]            cause_q;

	// result queue
	ptt_rsp_t head_q, tail_q;
	logic [1:0] fill_q;

	// next-state logic
	ptt_state_t            nx_state;
	logic [TIME_WIDTH-1:0] nx_ent;
	logic                  nx_mute, nx_held, nx_cons;
	logic [2:0]            nx_cause;
	logic                  ent_en, tone_en, mute_cmd, mute_arg, do_to, fin_rec, has_lim;
	logic [2:0]            tone_sel;
	logic [6:0]            act;
	logic [63:0]           now_ext;
	logic [TIME_WIDTH-1:0] now_t, elapsed;
	logic [CFG_W-1:0]      lim;
	logic                  tick_hit, too_short;
	ptt_rsp_t              res;
	logic                  push, pop;

	assign push = req_valid && !req_stall;
	assign pop  = rsp_valid && !rsp_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_thr_q  <= RST_ARM_THRESHOLD;
			min_rec_q  <= RST_MIN_RECORDING;
			max_rec_q  <= RST_MAX_RECORDING;
			resp_to_q  <= RST_RESPONSE_TIMEOUT;
			max_play_q <= RST_MAX_PLAYBACK;
			linger_q   <= RST_ERROR_LINGER;
			voice_en_q <= RST_VOICE_ENABLED;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ARM_THRESHOLD:    arm_thr_q  <= cfg_wdata;
				CFG_MIN_RECORDING:    min_rec_q  <= cfg_wdata;
				CFG_MAX_RECORDING:    max_rec_q  <= cfg_wdata;
				CFG_RESPONSE_TIMEOUT: resp_to_q  <= cfg_wdata;
				CFG_MAX_PLAYBACK:     max_play_q <= cfg_wdata;
				CFG_ERROR_LINGER:     linger_q   <= cfg_wdata;
				CFG_VOICE_ENABLED:    voice_en_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// timestamp in stored width, elapsed time clamps at zero
	assign now_ext = {32'd0, req.now_ms};
	assign now_t   = now_ext[TIME_WIDTH-1:0];
	assign elapsed = (now_t >= entered_q) ? (now_t - entered_q) : '0;

	// per-state timeout limit
	always_comb begin
		has_lim = 1'b1;
		case (state_q)
			ST_ARMED: lim = arm_thr_q;
			ST_REC:   lim = max_rec_q;
			ST_WAIT:  lim = resp_to_q;
			ST_PLAY:  lim = max_play_q;
			ST_ERROR: lim = linger_q;
			default: begin
				lim     = '0;
				has_lim = 1'b0;
			end
		endcase
	end

	assign tick_hit  = has_lim && (CMP_W'(elapsed) >= CMP_W'(lim));
	assign too_short = CMP_W'(elapsed) < CMP_W'(min_rec_q);

	// event decode
	always_comb begin
		nx_state = state_q;
		nx_ent   = entered_q;
		nx_mute  = mute_q;
		nx_held  = held_q;
		nx_cons  = cons_q;
		nx_cause = cause_q;
		ent_en   = 1'b0;
		tone_en  = 1'b0;
		tone_sel = TONE_ACK;
		act      = '0;
		mute_cmd = 1'b0;
		mute_arg = 1'b0;
		do_to    = 1'b0;
		fin_rec  = 1'b0;

		case (req.req_type)
			REQ_PRESS: begin
				if (!held_q) begin
					nx_held = 1'b1;
					if (state_q inside {ST_IDLE, ST_MUTED}) begin
						nx_cause = CAUSE_NONE;
						nx_cons  = 1'b0;
						tone_en  = 1'b1;
						tone_sel = TONE_ACK;
						ent_en   = 1'b1;
						nx_state = ST_ARMED;
					end
				end
			end
			REQ_RELEASE: begin
				nx_held = 1'b0;
				if (state_q inside {ST_MUTED, ST_ARMED}) begin
					ent_en   = 1'b1;
					nx_state = ST_IDLE;
				end else if (state_q == ST_REC) begin
					fin_rec = 1'b1;
				end
			end
			REQ_CANCEL: begin
				case (state_q)
					ST_REC: begin
						act      = ACT_MIC_STOP | ACT_DISCARD;
						ent_en   = 1'b1;
						nx_state = ST_IDLE;
					end
					ST_WAIT: begin
						act      = ACT_CANCEL;
						ent_en   = 1'b1;
						nx_state = ST_IDLE;
					end
					ST_PLAY: begin
						act      = ACT_PLAY_STOP;
						ent_en   = 1'b1;
						nx_state = ST_IDLE;
					end
					ST_ARMED, ST_ERROR, ST_MUTED: begin
						ent_en   = 1'b1;
						nx_state = ST_IDLE;
					end
					default: ;
				endcase
			end
			REQ_RESP_READY: begin
				if (state_q == ST_WAIT) begin
					tone_en = 1'b1;
					ent_en  = 1'b1;
					if (mute_q) begin
						tone_sel = TONE_MUTED;
						nx_state = ST_IDLE;
					end else begin
						tone_sel = TONE_READY;
						nx_state = ST_PLAY;
						act      = ACT_PLAY_START;
					end
				end
			end
			REQ_RESP_ANSWER: begin
				if (state_q == ST_WAIT) begin
					tone_en  = 1'b1;
					tone_sel = mute_q ? TONE_MUTED : TONE_READY;
					ent_en   = 1'b1;
					nx_state = ST_IDLE;
				end
			end
			REQ_RESP_FAILED: begin
				if (state_q == ST_WAIT) begin
					nx_cause = CAUSE_UPLOAD;
					act      = ACT_CANCEL;
					tone_en  = 1'b1;
					tone_sel = TONE_ERROR;
					ent_en   = 1'b1;
					nx_state = ST_ERROR;
				end
			end
			REQ_PLAY_DONE: begin
				if (state_q == ST_PLAY) begin
					ent_en   = 1'b1;
					nx_state = ST_IDLE;
				end
			end
			REQ_MUTE_TOGGLE: begin
				mute_cmd = 1'b1;
				mute_arg = !mute_q;
			end
			REQ_TIMEOUT: do_to = 1'b1;
			REQ_TICK:    do_to = tick_hit;
			REQ_SET_MUTE: begin
				mute_cmd = 1'b1;
				mute_arg = req.mute_value;
			end
			default: ;
		endcase

		// mute setting
		if (mute_cmd) begin
			nx_mute = mute_arg;
			if (!mute_arg) begin
				if (state_q == ST_MUTED) begin
					ent_en   = 1'b1;
					nx_state = ST_IDLE;
				end
			end else if (state_q inside {ST_REC, ST_PLAY, ST_ARMED}) begin
				if (state_q == ST_REC) act = ACT_MIC_STOP;
				if (state_q == ST_PLAY) act = ACT_PLAY_STOP;
				tone_en  = 1'b1;
				tone_sel = TONE_MUTED;
				ent_en   = 1'b1;
				nx_state = ST_IDLE;
			end else if (!mute_q) begin
				tone_en  = 1'b1;
				tone_sel = TONE_MUTED;
			end
		end

		// timeout rules
		if (do_to) begin
			case (state_q)
				ST_ARMED: begin
					tone_en = 1'b1;
					ent_en  = 1'b1;
					nx_cons = 1'b1;
					if (!voice_en_q) begin
						nx_cause = CAUSE_VOICE;
						tone_sel = TONE_MUTED;
						nx_state = ST_MUTED;
					end else if (mute_q) begin
						nx_cause = CAUSE_MUTED;
						tone_sel = TONE_MUTED;
						nx_state = ST_MUTED;
					end else if (!req.link_ready) begin
						nx_cause = CAUSE_LINK;
						tone_sel = TONE_ERROR;
						nx_state = ST_ERROR;
					end else begin
						tone_sel = TONE_LSTART;
						nx_state = ST_REC;
						act      = ACT_MIC_START;
					end
				end
				ST_REC: fin_rec = 1'b1;
				ST_WAIT: begin
					nx_cause = CAUSE_TIMEOUT;
					act      = ACT_CANCEL;
					tone_en  = 1'b1;
					tone_sel = TONE_ERROR;
					ent_en   = 1'b1;
					nx_state = ST_ERROR;
				end
				ST_PLAY: begin
					act      = ACT_PLAY_STOP;
					ent_en   = 1'b1;
					nx_state = ST_IDLE;
				end
				ST_ERROR, ST_MUTED: begin
					ent_en   = 1'b1;
					nx_state = ST_IDLE;
				end
				default: ;
			endcase
		end

		// end of a recording: keep or discard
		if (fin_rec) begin
			tone_en = 1'b1;
			ent_en  = 1'b1;
			if (too_short) begin
				nx_cause = CAUSE_SHORT;
				act      = ACT_MIC_STOP | ACT_DISCARD;
				tone_sel = TONE_MUTED;
				nx_state = ST_IDLE;
			end else begin
				act      = ACT_MIC_STOP | ACT_UPLOAD;
				tone_sel = TONE_LSTOP;
				nx_state = ST_WAIT;
			end
		end

		if (ent_en) nx_ent = now_t;
	end

	// result assembly
	always_comb begin
		res.mode       = mode_code(nx_state);
		res.led_update = ent_en;
		res.led_code   = ent_en ? led_of(nx_state) : LED_OFF;
		res.tone_valid = tone_en;
		res.tone_code  = tone_en ? tone_sel : TONE_ACK;
		res.cause      = nx_cause;
		res.actions    = act;
		res.muted_now  = nx_mute;
		res.press_used = nx_cons;
	end

	// controller state update on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			entered_q <= '0;
			mute_q    <= 1'b0;
			held_q    <= 1'b0;
			cons_q    <= 1'b0;
			cause_q   <= CAUSE_NONE;
		end else if (push) begin
			state_q   <= nx_state;
			entered_q <= nx_ent;
			mute_q    <= nx_mute;
			held_q    <= nx_held;
			cons_q    <= nx_cons;
			cause_q   <= nx_cause;
		end
	end

	// two-entry result queue: fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
		end else begin
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// two-entry result queue: payload
	always_ff @(posedge clk) begin
		if (push && (fill_q == 2'd0 || (fill_q == 2'd1 && pop))) begin
			head_q <= res;
		end else if (pop && fill_q == 2'd2) begin
			head_q <= tail_q;
		end
		if (push && fill_q == 2'd1 && !pop) begin
			tail_q <= res;
		end
	end

	assign req_stall = (fill_q == 2'd2);
	assign rsp_valid = (fill_q != 2'd0);
	assign rsp       = head_q;

	// checks
	`ASSERT_SAME(a_fill_bound, 1'b1, fill_q <= 2'd2, "result queue overfilled")
	`ASSERT_NEXT(a_beat_result, push, rsp_valid, "accepted beat left no result")
	`ASSERT_SAME(a_led_quiet, rsp_valid && !rsp.led_update, rsp.led_code == LED_OFF,
		"led code without led update")

endmodule
